@@ rtl/trd_pkg.sv @@
package trd_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_WIN1  = 2'd1;
	localparam logic [1:0] KIND_WIN2  = 2'd2;
	localparam logic [1:0] KIND_DATA  = 2'd3;

	localparam logic [1:0] NEED_NONE = 2'd0;
	localparam logic [1:0] NEED_WIN1 = 2'd1;
	localparam logic [1:0] NEED_WIN2 = 2'd2;
	localparam logic [1:0] NEED_DATA = 2'd3;

	localparam logic [5:0] WIN_BITS = 6'd32;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_LOAD1 = 3'd1,
		PH_LOAD2 = 3'd2,
		PH_BOTH  = 3'd3,
		PH_UNIT  = 3'd4,
		PH_RUN1  = 3'd5,
		PH_RUN2F = 3'd6,
		PH_RUN2  = 3'd7
	} phase_t;

	// what the back end has to emit for one accepted request
	typedef enum logic [2:0] {
		JOB_NONE  = 3'd0,	// one empty result
		JOB_RAW   = 3'd1,	// copy halfword
		JOB_RUN1  = 3'd2,	// 1bpp selector, four words
		JOB_RUN2F = 3'd3,	// first 2bpp selector, high byte only
		JOB_RUN2  = 3'd4	// 2bpp selector, two words
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [15:0] half;
		logic [15:0] colours;
		logic [1:0]  need;
		logic        done;
	} job_t;

	function automatic logic [1:0] need_of(input phase_t ph);
		logic [1:0] n;
		case (ph)
			PH_IDLE:  n = NEED_NONE;
			PH_LOAD1: n = NEED_WIN1;
			PH_BOTH:  n = NEED_WIN1;
			PH_LOAD2: n = NEED_WIN2;
			default:  n = NEED_DATA;
		endcase
		return n;
	endfunction

	// index of the final word of a job
	function automatic logic [1:0] last_index(input job_kind_t k);
		logic [1:0] n;
		case (k)
			JOB_RUN1: n = 2'd3;
			JOB_RUN2: n = 2'd1;
			default:  n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

@@ rtl/trd_front.sv @@
module trd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [1:0]    kind,
	input  logic [31:0]   value,
	output trd_pkg::job_t job
);
	import trd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [31:0] win1_q, win1_d;
	logic [31:0] win2_q, win2_d;
	logic [5:0]  win1_left_q, win1_left_d;
	logic [5:0]  win2_left_q, win2_left_d;
	logic [15:0] units_q, units_d;
	logic [15:0] colours_q, colours_d;
	logic [7:0]  repeat_q, repeat_d;

	logic [15:0] half;
	logic        is_data, unit_raw, run_end, unit_end, final_unit;
	logic [5:0]  win1_dec, win2_dec;
	logic        n1, n2;

	assign half       = value[15:0];
	assign is_data    = (kind == KIND_DATA);
	assign unit_raw   = is_data && (phase_q == PH_UNIT) && !win1_q[0];
	assign run_end    = is_data && (phase_q == PH_RUN1 || phase_q == PH_RUN2)
	                    && (repeat_q == 8'd0);
	assign unit_end   = unit_raw || run_end;
	assign final_unit = (units_q == 16'd0);
	assign win1_dec   = win1_left_q - 6'd1;
	assign win2_dec   = win2_left_q - 6'd1;
	assign n1         = (win1_dec == 6'd0);
	assign n2         = run_end && (win2_dec == 6'd0);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (kind == KIND_START) begin
			phase_d = PH_BOTH;
		end else if (unit_end) begin
			if (final_unit)  phase_d = PH_IDLE;
			else if (n1 && n2) phase_d = PH_BOTH;
			else if (n1)     phase_d = PH_LOAD1;
			else if (n2)     phase_d = PH_LOAD2;
			else             phase_d = PH_UNIT;
		end else begin
			case (phase_q)
				PH_LOAD1: if (kind == KIND_WIN1) phase_d = PH_UNIT;
				PH_BOTH:  if (kind == KIND_WIN1) phase_d = PH_LOAD2;
				PH_LOAD2: if (kind == KIND_WIN2) phase_d = PH_UNIT;
				PH_UNIT: begin
					if (is_data) phase_d = win2_q[0] ? PH_RUN2F : PH_RUN1;
				end
				PH_RUN2F: if (is_data) phase_d = PH_RUN2;
				default:  phase_d = phase_q;
			endcase
		end
	end

	// datapath and job
	always_comb begin
		win1_d      = win1_q;
		win2_d      = win2_q;
		win1_left_d = win1_left_q;
		win2_left_d = win2_left_q;
		units_d     = units_q;
		colours_d   = colours_q;
		repeat_d    = repeat_q;
		job.kind    = JOB_NONE;
		job.half    = half;
		job.colours = colours_q;
		job.need    = need_of(phase_d);
		job.done    = unit_end && final_unit && (kind != KIND_START);

		if (kind == KIND_START) begin
			units_d     = half;
			win1_left_d = WIN_BITS;
			win2_left_d = WIN_BITS;
			repeat_d    = 8'd0;
		end else begin
			case (phase_q)
				PH_LOAD1, PH_BOTH: if (kind == KIND_WIN1) win1_d = value;
				PH_LOAD2:          if (kind == KIND_WIN2) win2_d = value;
				PH_UNIT: begin
					if (is_data) begin
						win1_d = {win1_q[0], win1_q[31:1]};
						if (!win1_q[0]) begin
							job.kind = JOB_RAW;
						end else begin
							win2_d    = {win2_q[0], win2_q[31:1]};
							colours_d = half;
							if (!win2_q[0]) repeat_d = half[15:8];
						end
					end
				end
				PH_RUN1: begin
					if (is_data) begin
						job.kind = JOB_RUN1;
						if (repeat_q != 8'd0) repeat_d = repeat_q - 8'd1;
					end
				end
				PH_RUN2F: begin
					if (is_data) begin
						job.kind = JOB_RUN2F;
						repeat_d = half[7:0];
					end
				end
				PH_RUN2: begin
					if (is_data) begin
						job.kind = JOB_RUN2;
						if (repeat_q != 8'd0) repeat_d = repeat_q - 8'd1;
					end
				end
				default: ;
			endcase

			// window accounting at the end of a non-final unit
			if (unit_end && !final_unit) begin
				units_d     = units_q - 16'd1;
				win1_left_d = n1 ? WIN_BITS : win1_dec;
				if (run_end) win2_left_d = n2 ? WIN_BITS : win2_dec;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			win1_q      <= '0;
			win2_q      <= '0;
			win1_left_q <= WIN_BITS;
			win2_left_q <= WIN_BITS;
			units_q     <= '0;
			colours_q   <= '0;
			repeat_q    <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			win1_q      <= win1_d;
			win2_q      <= win2_d;
			win1_left_q <= win1_left_d;
			win2_left_q <= win2_left_d;
			units_q     <= units_d;
			colours_q   <= colours_d;
			repeat_q    <= repeat_d;
		end
	end

endmodule

@@ rtl/trd_queue.sv @@
module trd_queue #(
	parameter int DEPTH = trd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  trd_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output trd_pkg::job_t rd_data,
	output logic          rd_avail
);
	import trd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full     = (count_q == CNT_FULL);
	assign rd_avail = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_avail;

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd) rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd)      count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr) count_q <= count_q - CW'(1);
		end
	end

endmodule

@@ rtl/trd_back.sv @@
module trd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  trd_pkg::job_t job,
	input  logic          job_avail,
	output logic          job_take,
	output logic          empty,
	input  logic          pop,
	output logic [15:0]   pixel_word,
	output logic          word_valid,
	output logic [1:0]    need_next,
	output logic          done_res,
	output logic          last
);
	import trd_pkg::*;

	logic        out_valid_q;
	logic [15:0] word_q;
	logic        valid_q, done_q, last_q;
	logic [1:0]  need_q;
	logic [1:0]  idx_q;

	logic        load, last_word, hi_byte;
	logic [15:0] word_d;
	logic        valid_d;
	logic [1:0]  sel;
	logic [3:0]  bit_idx;

	assign load      = job_avail && (!out_valid_q || pop);
	assign last_word = (idx_q == last_index(job.kind));
	assign job_take  = load && last_word;
	// 2bpp: the first selector and the second word of a pair use the high byte
	assign hi_byte   = (job.kind == JOB_RUN2F) || (idx_q == 2'd1);

	always_comb begin
		word_d  = '0;
		valid_d = 1'b1;
		sel     = '0;
		bit_idx = '0;
		case (job.kind)
			JOB_RAW: word_d = job.half;
			JOB_RUN1: begin
				for (int j = 0; j < 4; j++) begin
					bit_idx = {idx_q, 2'(j)};
					word_d[4*j +: 4] = job.half[bit_idx] ? job.colours[7:4]
					                                     : job.colours[3:0];
				end
			end
			JOB_RUN2F, JOB_RUN2: begin
				for (int j = 0; j < 4; j++) begin
					sel = job.half[{hi_byte, 3'(2*j)} +: 2];
					word_d[4*j +: 4] = job.colours[{sel, 2'b00} +: 4];
				end
			end
			default: valid_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= last_word ? 2'd0 : idx_q + 2'd1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q  <= word_d;
			valid_q <= valid_d;
			need_q  <= job.need;
			done_q  <= job.done;
			last_q  <= last_word;
		end
	end

	assign empty      = !out_valid_q;
	assign pixel_word = word_q;
	assign word_valid = valid_q;
	assign need_next  = need_q;
	assign done_res   = done_q;
	assign last       = last_q;

endmodule

@@ rtl/tile_run_decompressor_4bpp.sv @@
// channel   | handshake        | payload
// ----------+------------------+------------------------------------------------
// input     | push / full      | kind[1:0], value[31:0]
// result    | pop / empty      | pixel_word[15:0], word_valid, need_next[1:0],
//           |                  | done_res, last
//
// One request is taken per cycle while full is low; the front end decodes it in
// that cycle and queues a job. The back end emits one result word per cycle
// while pop is high, from its single result register; a request yields one
// word (raw, empty, first 2bpp), two (2bpp selector) or four (1bpp selector).
// Reset clears the queue, the result register and the decode phase (idle).
// A low pop holds the result; the queue fills behind it and then full rises.
module tile_run_decompressor_4bpp #(
	parameter int QUEUE_DEPTH = trd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic [31:0] value,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] pixel_word,
	output logic        word_valid,
	output logic [1:0]  need_next,
	output logic        done_res,
	output logic        last
);
	import trd_pkg::*;

	job_t front_job, queued_job;
	logic accept, job_avail, job_take;

	// a request moves only when the queue has room for its job
	assign accept = push && !full;

	// front end: window bookkeeping, phase tracking, classification
	trd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.kind   (kind),
		.value  (value),
		.job    (front_job)
	);

	// short job queue decoupling intake from word expansion
	trd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_data  (front_job),
		.full     (full),
		.rd_en    (job_take),
		.rd_data  (queued_job),
		.rd_avail (job_avail)
	);

	// back end: expands each job into its result words
	trd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (queued_job),
		.job_avail  (job_avail),
		.job_take   (job_take),
		.empty      (empty),
		.pop        (pop),
		.pixel_word (pixel_word),
		.word_valid (word_valid),
		.need_next  (need_next),
		.done_res   (done_res),
		.last       (last)
	);

endmodule

@@ tb/tile_run_decompressor_4bpp_tb.sv @@
module tile_run_decompressor_4bpp_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import trd_pkg::*;

	// cycles with no request or result moving before the run is called hung;
	// the longest legal quiet stretch is the receiver hold-off below
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int DECODED_TARGET = 250;

	typedef struct packed {
		logic [15:0] pixel_word;
		logic        word_valid;
		logic [1:0]  need_next;
		logic        done_res;
		logic        last;
	} pixel_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  kind = KIND_START;
	logic [31:0] value = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] pixel_word;
	logic        word_valid;
	logic [1:0]  need_next;
	logic        done_res;
	logic        last;

	// predicted decoder state, updated at the edge a request is taken
	phase_t      dec_phase;
	logic [31:0] win_one, win_two;
	logic [5:0]  win_one_left, win_two_left;
	logic [16:0] units_left;
	logic [15:0] colour_set;
	logic [7:0]  repeat_left;

	pixel_result_t expected_words[$];

	int  errors = 0;
	int  decoded_count = 0;	// requests that the decoder acted on
	int  burst_left = 0;
	bit  gaps_on = 1'b1;
	int  hold_request = 0;	// set by a test, picked up by the receiver

	tile_run_decompressor_4bpp dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.value      (value),
		.empty      (empty),
		.pop        (pop),
		.pixel_word (pixel_word),
		.word_valid (word_valid),
		.need_next  (need_next),
		.done_res   (done_res),
		.last       (last)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic void clear_decoder();
		dec_phase = PH_IDLE;
		win_one = '0;
		win_two = '0;
		win_one_left = WIN_BITS;
		win_two_left = WIN_BITS;
		units_left = '0;
		colour_set = '0;
		repeat_left = '0;
	endfunction

	// need_next as reported on every result
	function automatic logic [1:0] wanted_need();
		case (dec_phase)
			PH_IDLE:          return NEED_NONE;
			PH_LOAD1, PH_BOTH: return NEED_WIN1;
			PH_LOAD2:         return NEED_WIN2;
			default:          return NEED_DATA;
		endcase
	endfunction

	// request kind the decoder will act on next (never called while idle)
	function automatic logic [1:0] wanted_kind();
		case (dec_phase)
			PH_LOAD1, PH_BOTH: return KIND_WIN1;
			PH_LOAD2:         return KIND_WIN2;
			default:          return KIND_DATA;
		endcase
	endfunction

	// four pixels from 2-bit selectors starting at bit sel_base
	function automatic logic [15:0] map_2bpp(logic [15:0] sel, int sel_base);
		logic [15:0] word;
		logic [1:0]  idx;
		word = '0;
		for (int j = 0; j < 4; j++) begin
			idx = sel[sel_base + 2 * j +: 2];
			word[4 * j +: 4] = colour_set[4 * idx +: 4];
		end
		return word;
	endfunction

	// word w of a 1bpp selector: bits 4w..4w+3 pick colour 1 or colour 0
	function automatic logic [15:0] map_1bpp(logic [15:0] sel, int w);
		logic [15:0] word;
		for (int j = 0; j < 4; j++)
			word[4 * j +: 4] = sel[4 * w + j] ? colour_set[7:4] : colour_set[3:0];
		return word;
	endfunction

	// end of a unit: the final one goes idle and uses no window bits,
	// otherwise count down and ask for whichever windows ran out
	function automatic bit close_unit(bit was_run);
		bit due_one, due_two;
		due_one = 1'b0;
		due_two = 1'b0;
		if (units_left == 0) begin
			dec_phase = PH_IDLE;
			return 1'b1;
		end
		units_left = units_left - 1'b1;
		if (was_run) begin
			win_two_left = win_two_left - 1'b1;
			if (win_two_left == 0) begin
				win_two_left = WIN_BITS;
				due_two = 1'b1;
			end
		end
		win_one_left = win_one_left - 1'b1;
		if (win_one_left == 0) begin
			win_one_left = WIN_BITS;
			due_one = 1'b1;
		end
		if (due_one && due_two)
			dec_phase = PH_BOTH;
		else if (due_one)
			dec_phase = PH_LOAD1;
		else if (due_two)
			dec_phase = PH_LOAD2;
		else
			dec_phase = PH_UNIT;
		return 1'b0;
	endfunction

	// expected results of one accepted request
	task automatic predict_words(logic [1:0] k, logic [31:0] v);
		logic [15:0]   half;
		logic [15:0]   words[4];
		int            n;
		bit            done, taken, b1, b2;
		pixel_result_t r;
		half = v[15:0];
		n = 0;
		done = 1'b0;
		taken = 1'b1;
		if (k == KIND_START) begin
			// start aborts whatever is in flight
			units_left = {1'b0, half};
			win_one_left = WIN_BITS;
			win_two_left = WIN_BITS;
			repeat_left = '0;
			dec_phase = PH_BOTH;
		end else if (k == KIND_WIN1 && (dec_phase == PH_LOAD1 || dec_phase == PH_BOTH)) begin
			win_one = v;
			dec_phase = (dec_phase == PH_BOTH) ? PH_LOAD2 : PH_UNIT;
		end else if (k == KIND_WIN2 && dec_phase == PH_LOAD2) begin
			win_two = v;
			dec_phase = PH_UNIT;
		end else if (k == KIND_DATA && dec_phase == PH_UNIT) begin
			b1 = win_one[0];
			win_one = {win_one[0], win_one[31:1]};
			if (!b1) begin
				words[0] = half;
				n = 1;
				done = close_unit(1'b0);
			end else begin
				b2 = win_two[0];
				win_two = {win_two[0], win_two[31:1]};
				colour_set = half;
				if (!b2) begin
					repeat_left = half[15:8];
					dec_phase = PH_RUN1;
				end else begin
					dec_phase = PH_RUN2F;
				end
			end
		end else if (k == KIND_DATA && dec_phase == PH_RUN1) begin
			for (int w = 0; w < 4; w++)
				words[w] = map_1bpp(half, w);
			n = 4;
			if (repeat_left == 0)
				done = close_unit(1'b1);
			else
				repeat_left = repeat_left - 1'b1;
		end else if (k == KIND_DATA && dec_phase == PH_RUN2F) begin
			words[0] = map_2bpp(half, 8);
			n = 1;
			repeat_left = half[7:0];
			dec_phase = PH_RUN2;
		end else if (k == KIND_DATA && dec_phase == PH_RUN2) begin
			words[0] = map_2bpp(half, 0);
			words[1] = map_2bpp(half, 8);
			n = 2;
			if (repeat_left == 0)
				done = close_unit(1'b1);
			else
				repeat_left = repeat_left - 1'b1;
		end else begin
			taken = 1'b0;
		end

		if (taken)
			decoded_count++;
		// an ignored request, or one that only loads state, still gives
		// one empty result
		if (n == 0) begin
			r = '{pixel_word: '0, word_valid: 1'b0, need_next: wanted_need(),
				done_res: done, last: 1'b1};
			expected_words.push_back(r);
		end
		for (int i = 0; i < n; i++) begin
			r = '{pixel_word: words[i], word_valid: 1'b1, need_next: wanted_need(),
				done_res: done, last: (i == n - 1)};
			expected_words.push_back(r);
		end
	endtask

	// ------------------------------------------------------------------
	// Request side: bursts of random length with random gaps in between
	// ------------------------------------------------------------------

	task automatic send_request(logic [1:0] k, logic [31:0] v);
		int gap;
		if (gaps_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, 6);
				@(negedge clk) push <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left--;
		end
		@(negedge clk);
		push <= 1'b1;
		kind <= k;
		value <= v;
		// full is sampled before the edge updates it
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_words(k, v);
	endtask

	// repeat count of a run, random from 0 up to max_count
	function automatic logic [7:0] run_count(int max_count);
		return 8'($urandom_range(0, max_count));
	endfunction

	// data halfword shaped by the predicted state: the repeat count byte
	// of a run is kept at or below max_count, everything else is random
	function automatic logic [15:0] data_half(int max_count);
		logic [15:0] h;
		h = 16'($urandom());
		if (dec_phase == PH_UNIT && win_one[0] && !win_two[0])
			h[15:8] = run_count(max_count);
		else if (dec_phase == PH_RUN2F)
			h[7:0] = run_count(max_count);
		return h;
	endfunction

	// one well-formed frame from start to the final unit. With fixed
	// windows, the first window one is given and later ones are all runs.
	// noise_pct of the requests are of a random kind (a start among them
	// aborts and restarts with a few units).
	task automatic run_frame(logic [15:0] units_m1, bit fixed_windows,
			logic [31:0] first_win_one, int noise_pct, int max_count);
		bit          first_one;
		logic [1:0]  k;
		logic [31:0] v;
		first_one = 1'b1;
		v = $urandom();
		v[15:0] = units_m1;
		send_request(KIND_START, v);
		while (dec_phase != PH_IDLE) begin
			k = wanted_kind();
			v = $urandom();
			if ($urandom_range(0, 99) < noise_pct) begin
				k = 2'($urandom_range(0, 3));
				if (k == KIND_START)
					v[15:3] = '0;
			end else if (k == KIND_WIN1 && fixed_windows) begin
				v = first_one ? first_win_one : '1;
				first_one = 1'b0;
			end else if (k == KIND_DATA) begin
				v[15:0] = data_half(max_count);
			end
			send_request(k, v);
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: own stall pattern, plus a long hold-off on request
	// ------------------------------------------------------------------

	int rx_cycle = 0;
	int rx_mode = 0;
	int hold_cnt = 0;

	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_cnt = hold_request;
			hold_request = 0;
		end
		rx_cycle++;
		if (rx_cycle % 80 == 0)
			rx_mode = $urandom_range(0, 3);
		if (hold_cnt != 0) begin
			hold_cnt--;
			pop <= 1'b0;
		end else begin
			case (rx_mode)
				0: pop <= 1'b1;		// no stalls
				1: pop <= 1'($urandom_range(0, 1));
				2: pop <= (rx_cycle % 4 == 0);
				default: pop <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// compare each popped word with the oldest expectation
	always @(posedge clk) begin
		pixel_result_t exp_r;
		if (arst_n && pop && !empty) begin
			if (expected_words.size() == 0) begin
				$error("result with nothing pending: pixel_word %h", pixel_word);
				errors++;
			end else begin
				exp_r = expected_words.pop_front();
				if (pixel_word !== exp_r.pixel_word) begin
					$error("pixel_word: expected %h, got %h", exp_r.pixel_word, pixel_word);
					errors++;
				end
				if (word_valid !== exp_r.word_valid) begin
					$error("word_valid: expected %b, got %b", exp_r.word_valid, word_valid);
					errors++;
				end
				if (need_next !== exp_r.need_next) begin
					$error("need_next: expected %0d, got %0d", exp_r.need_next, need_next);
					errors++;
				end
				if (done_res !== exp_r.done_res) begin
					$error("done_res: expected %b, got %b", exp_r.done_res, done_res);
					errors++;
				end
				if (last !== exp_r.last) begin
					$error("last: expected %b, got %b", exp_r.last, last);
					errors++;
				end
			end
		end
	end

	// hang detector: counts cycles in which neither side moves
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[tile_run_decompressor_4bpp] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// control and data requests while idle are ignored
	task automatic test_idle_requests();
		send_request(KIND_DATA, 32'hFFFF_FFFF);
		send_request(KIND_WIN1, 32'h0000_0000);
		send_request(KIND_WIN2, 32'hFFFF_FFFF);
	endtask

	// single unit, wrong kinds along the way, raw copy with wide value
	task automatic test_raw_unit();
		send_request(KIND_START, 32'hFFFF_0000);	// one unit, upper bits ignored
		send_request(KIND_WIN2, 32'h1234_5678);	// wrong kind, window one is due
		send_request(KIND_WIN1, 32'h0000_0000);
		send_request(KIND_DATA, 32'h0000_FFFF);	// wrong kind, window two is due
		send_request(KIND_WIN2, 32'h0000_0000);
		send_request(KIND_WIN1, 32'hFFFF_FFFF);	// wrong kind during units
		send_request(KIND_DATA, 32'hFFFF_FFFF);	// raw copy, final unit
		send_request(KIND_DATA, 32'h0000_FFFF);	// ignored, the decoder is idle again
	endtask

	// both run kinds, then a start that aborts a 2bpp run midway
	task automatic test_runs_and_abort();
		send_request(KIND_START, 32'h0000_FFFF);	// largest unit count
		send_request(KIND_WIN1, 32'hFFFF_FFFF);
		send_request(KIND_WIN2, 32'hAAAA_AAAA);
		send_request(KIND_DATA, 32'h0000_01F0);	// 1bpp, colours 0/F, count 1
		send_request(KIND_DATA, 32'h0000_A5C3);
		send_request(KIND_DATA, 32'h0000_0F0F);
		send_request(KIND_DATA, 32'h0000_E41B);	// 2bpp colour set
		send_request(KIND_DATA, 32'h0000_1B01);	// first selector, count 1
		send_request(KIND_DATA, 32'h0000_FFFF);
		send_request(KIND_START, 32'hFFFF_0001);	// abort, two units
		send_request(KIND_WIN1, 32'h0000_0002);
		send_request(KIND_WIN2, 32'h0000_0000);
		send_request(KIND_DATA, 32'h0000_8001);	// raw
		send_request(KIND_DATA, 32'h0000_0010);	// 1bpp, count 0
		send_request(KIND_DATA, 32'h0000_8000);	// final unit
	endtask

	// window refills: first frame has one raw unit, so window one runs out
	// alone and window two one unit later; second frame is all runs, so
	// both run out together
	task automatic test_window_refill();
		gaps_on = 1'b1;
		run_frame(16'd33, 1'b1, 32'hFFFF_FFFE, 0, 0);
		gaps_on = 1'b0;
		run_frame(16'd33, 1'b1, 32'hFFFF_FFFF, 0, 0);
	endtask

	// receiver holds off while requests keep coming: the block backs up
	// and raises full
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_request = HOLD_OFF_CYCLES;
		run_frame(16'd4, 1'b0, '0, 0, 2);
		run_frame(16'd3, 1'b0, '0, 0, 2);
	endtask

	// random frames with some stray requests and now and then a long run
	task automatic test_random_frames();
		while (decoded_count < DECODED_TARGET) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			run_frame(16'($urandom_range(0, 6)), 1'b0, '0, 8,
				($urandom_range(0, 7) == 0) ? 24 : 2);
		end
	endtask

	initial begin
		clear_decoder();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_idle_requests();
		test_raw_unit();
		test_runs_and_abort();
		test_window_refill();
		test_backpressure();
		test_random_frames();

		@(negedge clk) push <= 1'b0;
		// the watchdog bounds this wait
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("[tile_run_decompressor_4bpp] OK");
		else
			$display("[tile_run_decompressor_4bpp] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
rtl/trd_pkg.sv
rtl/trd_front.sv
rtl/trd_queue.sv
rtl/trd_back.sv
rtl/tile_run_decompressor_4bpp.sv
tb/tile_run_decompressor_4bpp_tb.sv
